FILE: rtl/core/swcrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcrc_pkg
// Shared types, codes and the CRC-32 byte step for the stop-and-wait
// packet receiver.
// ----------------------------------------------------------------------------
package swcrc_pkg;

  // Field widths fixed by the packet format.
  localparam int DATA_W  = 8;
  localparam int ID_W    = 32;
  localparam int CRC_W   = 32;
  localparam int COUNT_W = 11;
  localparam int VERD_W  = 2;

  // Register file geometry.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Defaults and constants.
  localparam int                 MAX_PAYLOAD_DEF = 1024;
  localparam logic [CRC_W-1:0]   CRC_POLY        = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0]   CRC_SEED_RESET  = 32'hFFFF_FFFF;
  localparam logic [ID_W-1:0]    SEQ_RESET       = 32'd1;

  // Verdict codes.
  localparam logic [VERD_W-1:0] VERDICT_ACCEPT  = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_CRC_ERR = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_DUP     = 2'd2;

  // Outcome of one byte, handed from the check engine to the top level.
  typedef struct packed {
    logic                fire;
    logic [ID_W-1:0]     ack_id;
    logic [COUNT_W-1:0]  ack_count;
    logic                error_flag;
    logic [VERD_W-1:0]   verdict;
  } swcrc_result_t;

  // One reflected CRC-32 byte step: eight shift/XOR steps on the low byte.
  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                input logic [DATA_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c ^ {8'd0, crc[31:8]};
  endfunction

endpackage

FILE: rtl/core/stop_wait_crc_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_wait_crc_receiver_top
// Stop-and-wait packet receiver with a reflected CRC-32 check per packet.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-----------------------------------
//  in_      | input     | in_valid/in_stall  | data_byte, last_byte, packet_id,
//           |           |                    | received_crc, valid_count
//  out_     | output    | out_valid/out_stall| ack_id, ack_count, error_flag,
//           |           |                    | verdict
//  cfg_     | input     | APB write/read     | crc_seed at byte address 0
//
// One byte is taken per cycle while in_stall is low. A last byte passes from the
// input register through the byte step, and its result is registered in the
// output register. The running CRC register feeds back through one byte step.
// Reset (rst_n low, synchronous) loads the seed 0xFFFFFFFF and expects id 1.
// A stalled result holds the output register and, once the input register
// is also full, raises in_stall.
// ----------------------------------------------------------------------------
module stop_wait_crc_receiver_top
  import swcrc_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_W-1:0]     in_data_byte,
  input  logic                  in_last_byte,
  input  logic [ID_W-1:0]       in_packet_id,
  input  logic [CRC_W-1:0]      in_received_crc,
  input  logic [COUNT_W-1:0]    in_valid_count,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ID_W-1:0]       out_ack_id,
  output logic [COUNT_W-1:0]    out_ack_count,
  output logic                  out_error_flag,
  output logic [VERD_W-1:0]     out_verdict,
  // Configuration port.
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic                 cfg_wr;
  logic                 seed_sel;
  logic [CRC_W-1:0]     crc_seed_r;
  logic [CRC_W-1:0]     crc_running_r;
  logic [ID_W-1:0]      expected_seq_r;

  logic                 s1_valid_r;
  logic [DATA_W-1:0]    s1_data_r;
  logic                 s1_last_r;
  logic [ID_W-1:0]      s1_id_r;
  logic [CRC_W-1:0]     s1_crc_r;
  logic [COUNT_W-1:0]   s1_count_r;
  logic                 s1_adv;
  logic                 s1_proc;
  logic                 in_acc;

  logic [CRC_W-1:0]     crc_nxt;
  logic [ID_W-1:0]      seq_nxt;
  swcrc_result_t        eng_res;

  logic                 out_valid_r;
  logic [ID_W-1:0]      out_ack_id_r;
  logic [COUNT_W-1:0]   out_ack_count_r;
  logic                 out_error_flag_r;
  logic [VERD_W-1:0]    out_verdict_r;

  // Register port: single register at word 0; other words ignore writes.
  assign cfg_pready = 1'b1;
  assign seed_sel   = (cfg_paddr[2] == 1'b0);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = seed_sel ? crc_seed_r : '0;

  // Pipeline control: the input register drains when the output register is free.
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;
  assign s1_proc  = s1_valid_r && s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r  <= in_data_byte;
      s1_last_r  <= in_last_byte;
      s1_id_r    <= in_packet_id;
      s1_crc_r   <= in_received_crc;
      s1_count_r <= in_valid_count;
    end
  end

  // Byte step and verdict.
  swcrc_engine #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_engine (
    .data_byte    (s1_data_r),
    .last_byte    (s1_last_r),
    .packet_id    (s1_id_r),
    .received_crc (s1_crc_r),
    .valid_count  (s1_count_r),
    .crc_running  (crc_running_r),
    .expected_seq (expected_seq_r),
    .crc_nxt      (crc_nxt),
    .seq_nxt      (seq_nxt),
    .result       (eng_res)
  );

  // Seed, running CRC and expected sequence number. A seed write restarts the packet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_seed_r     <= CRC_SEED_RESET;
      crc_running_r  <= CRC_SEED_RESET;
      expected_seq_r <= SEQ_RESET;
    end else begin
      if (cfg_wr && seed_sel) begin
        crc_seed_r    <= cfg_pwdata;
        crc_running_r <= cfg_pwdata;
      end else if (s1_proc) begin
        crc_running_r <= s1_last_r ? crc_seed_r : crc_nxt;
      end
      if (s1_proc) begin
        expected_seq_r <= seq_nxt;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_proc && eng_res.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_proc && eng_res.fire) begin
      out_ack_id_r     <= eng_res.ack_id;
      out_ack_count_r  <= eng_res.ack_count;
      out_error_flag_r <= eng_res.error_flag;
      out_verdict_r    <= eng_res.verdict;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ack_id     = out_ack_id_r;
  assign out_ack_count  = out_ack_count_r;
  assign out_error_flag = out_error_flag_r;
  assign out_verdict    = out_verdict_r;

`ifndef SYNTHESIS
  // Input only stalls when both registers are full and the output is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("in_stall raised without a full, held pipeline");

  // A good acknowledgement advances the expected id by exactly one.
  a_seq_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_proc && eng_res.fire && (eng_res.verdict == VERDICT_ACCEPT))
      |=> (expected_seq_r == $past(expected_seq_r) + 32'd1))
    else $error("expected sequence did not advance on accept");

  // After a last byte the running CRC restarts from the seed.
  a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_proc && s1_last_r) |=> (crc_running_r == crc_seed_r))
    else $error("running CRC not reloaded after last byte");

  // The error flag is set exactly for a CRC error verdict.
  a_err_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_error_flag_r == (out_verdict_r == VERDICT_CRC_ERR)))
    else $error("error flag disagrees with verdict");
`endif

endmodule

FILE: rtl/core/swcrc_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcrc_engine
// Per-byte logic: folds one byte into the running CRC and, on the last
// byte of a packet, decides the acknowledgement and the next sequence number.
// ----------------------------------------------------------------------------
module swcrc_engine
  import swcrc_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic [DATA_W-1:0]  data_byte,
  input  logic               last_byte,
  input  logic [ID_W-1:0]    packet_id,
  input  logic [CRC_W-1:0]   received_crc,
  input  logic [COUNT_W-1:0] valid_count,
  input  logic [CRC_W-1:0]   crc_running,
  input  logic [ID_W-1:0]    expected_seq,
  output logic [CRC_W-1:0]   crc_nxt,
  output logic [ID_W-1:0]    seq_nxt,
  output swcrc_result_t      result
);

  localparam int CMP_W = 17;
  localparam logic [CMP_W-1:0] MaxPay = CMP_W'(MAX_PAYLOAD);

  logic id_match;
  logic id_older;
  logic crc_good;
  logic count_over;

  // CRC step and header comparisons.
  assign crc_nxt    = crc_fold(crc_running, data_byte);
  assign id_match   = (packet_id == expected_seq);
  assign id_older   = (packet_id < expected_seq);
  assign crc_good   = (received_crc == crc_nxt);
  assign count_over = ({{(CMP_W-COUNT_W){1'b0}}, valid_count} > MaxPay);

  // Verdict and sequence update; a newer id gives no answer.
  always_comb begin
    seq_nxt           = expected_seq;
    result.fire       = 1'b0;
    result.verdict    = VERDICT_ACCEPT;
    result.ack_id     = packet_id;
    result.ack_count  = count_over ? MaxPay[COUNT_W-1:0] : valid_count;
    if (last_byte) begin
      priority if (id_match && crc_good) begin
        result.fire    = 1'b1;
        result.verdict = VERDICT_ACCEPT;
        seq_nxt        = expected_seq + 32'd1;
      end else if (id_match) begin
        result.fire    = 1'b1;
        result.verdict = VERDICT_CRC_ERR;
      end else if (id_older) begin
        result.fire    = 1'b1;
        result.verdict = VERDICT_DUP;
      end else begin
        result.fire    = 1'b0;
      end
    end
    result.error_flag = (result.verdict == VERDICT_CRC_ERR);
  end

endmodule

FILE: dv/stop_wait_crc_receiver_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_wait_crc_receiver_top_tb
// Drives byte streams of packets into the stop-and-wait receiver and checks
// every acknowledgement against a CRC-32 and sequence-number tracker kept
// here. A directed opening covers the field extremes and each verdict. After
// that, four random phases under different CRC seeds mix well-formed packets
// with bad-CRC, old-id and new-id packets. Random idle cycles and
// back-pressure run on both channels.
// ----------------------------------------------------------------------------
module stop_wait_crc_receiver_top_tb;
  import swcrc_pkg::*;

  localparam int                    PAYLOAD_CAP  = MAX_PAYLOAD_DEF;
  localparam logic [APB_ADDR_W-1:0] SEED_ADDR    = '0;
  localparam int                    DRAIN_CYCLES = 4;
  localparam int                    PHASE_BYTES  = 320;

  // One acknowledgement as seen on the result channel.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [COUNT_W-1:0] count;
    logic               err;
    logic [VERD_W-1:0]  verdict;
  } ack_t;

  // Kinds of packet ending the stimulus can produce.
  typedef enum int {PKT_GOOD, PKT_BAD_CRC, PKT_OLD, PKT_NEW, PKT_NEW_TOP} pkt_kind_t;

  // Tracks the receiver's CRC and sequence state and the acks still owed.
  class ack_tracker;
    logic [CRC_W-1:0] seed;
    logic [CRC_W-1:0] running;
    logic [ID_W-1:0]  next_seq;
    ack_t             awaited_acks[$];
    int               mismatches;

    function new();
      seed       = CRC_SEED_RESET;
      running    = CRC_SEED_RESET;
      next_seq   = SEQ_RESET;
      mismatches = 0;
    endfunction

    // Reflected CRC-32 over one byte, shifting one data bit per step.
    static function logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] crc,
                                               logic [DATA_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc;
      for (int i = 0; i < DATA_W; i++) begin
        if (c[0] ^ b[i]) begin
          c = (c >> 1) ^ CRC_POLY;
        end else begin
          c = c >> 1;
        end
      end
      return c;
    endfunction

    // A seed write also restarts any packet in progress.
    function void load_seed(logic [CRC_W-1:0] v);
      seed    = v;
      running = v;
    endfunction

    // Folds one transferred byte and queues the ack it causes, if any.
    function void take_byte(logic [DATA_W-1:0] b, logic last, logic [ID_W-1:0] id,
                            logic [CRC_W-1:0] rcrc, logic [COUNT_W-1:0] cnt);
      logic [CRC_W-1:0] crc;
      ack_t             a;
      crc = crc_step(running, b);
      if (!last) begin
        running = crc;
        return;
      end
      running = seed;
      if (id == next_seq) begin
        if (rcrc == crc) begin
          a.verdict = VERDICT_ACCEPT;
          next_seq  = next_seq + 1'b1;
        end else begin
          a.verdict = VERDICT_CRC_ERR;
        end
      end else if (id < next_seq) begin
        a.verdict = VERDICT_DUP;
      end else begin
        // A packet from the future is dropped silently.
        return;
      end
      a.id    = id;
      a.count = (cnt > PAYLOAD_CAP) ? COUNT_W'(PAYLOAD_CAP) : cnt;
      a.err   = (a.verdict == VERDICT_CRC_ERR);
      awaited_acks.push_back(a);
    endfunction

    function void report_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      end
    endfunction

    // Compares one transferred ack with the oldest one owed.
    function void check_ack(logic [ID_W-1:0] id, logic [COUNT_W-1:0] cnt,
                            logic err, logic [VERD_W-1:0] verdict);
      ack_t want;
      if (awaited_acks.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected ack: expected none, got id %h verdict %0d",
                 $time, id, verdict);
        return;
      end
      want = awaited_acks.pop_front();
      report_field("ack_id", want.id, id);
      report_field("ack_count", 32'(want.count), 32'(cnt));
      report_field("error_flag", 32'(want.err), 32'(err));
      report_field("verdict", 32'(want.verdict), 32'(verdict));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [DATA_W-1:0]     in_data_byte = '0;
  logic                  in_last_byte = 1'b0;
  logic [ID_W-1:0]       in_packet_id = '0;
  logic [CRC_W-1:0]      in_received_crc = '0;
  logic [COUNT_W-1:0]    in_valid_count = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ID_W-1:0]       out_ack_id;
  logic [COUNT_W-1:0]    out_ack_count;
  logic                  out_error_flag;
  logic [VERD_W-1:0]     out_verdict;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  ack_tracker sb;
  bit         hush = 1'b0;
  int         bytes_sent = 0;
  int         stall_left = 0;

  stop_wait_crc_receiver_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .in_packet_id   (in_packet_id),
    .in_received_crc(in_received_crc),
    .in_valid_count (in_valid_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ack_id     (out_ack_id),
    .out_ack_count  (out_ack_count),
    .out_error_flag (out_error_flag),
    .out_verdict    (out_verdict),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result-side back-pressure: scattered single cycles plus rare long bursts.
  always @(negedge clk) begin
    if (hush) begin
      stall_left = 0;
      out_stall  = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if ($urandom_range(299, 0) == 0) begin
      stall_left = $urandom_range(20, 8);
      out_stall  = 1'b1;
    end else begin
      out_stall = ($urandom_range(99, 0) < 11);
    end
  end

  // Every ack transfer is checked as it happens.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_ack(out_ack_id, out_ack_count, out_error_flag, out_verdict);
    end
  end

  // One byte transfer, with an optional idle cycle in front of it.
  task automatic send_byte(input logic [DATA_W-1:0] b, input logic last,
                           input logic [ID_W-1:0] id, input logic [CRC_W-1:0] rcrc,
                           input logic [COUNT_W-1:0] cnt);
    @(negedge clk);
    if (!hush && $urandom_range(99, 0) < 11) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_data_byte    = b;
    in_last_byte    = last;
    in_packet_id    = id;
    in_received_crc = rcrc;
    in_valid_count  = cnt;
    do @(posedge clk); while (in_stall);
    sb.take_byte(b, last, id, rcrc, cnt);
    bytes_sent++;
  endtask

  // A packet of nbytes; the header on the last byte is shaped by kind.
  // A negative fill gives random payload bytes.
  task automatic send_packet(input int nbytes, input pkt_kind_t kind,
                             input logic [COUNT_W-1:0] cnt, input int fill);
    logic [DATA_W-1:0] b;
    logic [CRC_W-1:0]  crc;
    logic [ID_W-1:0]   id;
    longint unsigned   span;
    for (int i = 0; i < nbytes - 1; i++) begin
      b = (fill < 0) ? DATA_W'($urandom()) : DATA_W'(fill);
      send_byte(b, 1'b0, $urandom(), $urandom(), COUNT_W'($urandom_range(2047, 0)));
    end
    b   = (fill < 0) ? DATA_W'($urandom()) : DATA_W'(fill);
    crc = ack_tracker::crc_step(sb.running, b);
    id  = sb.next_seq;
    case (kind)
      PKT_BAD_CRC: begin
        crc = crc ^ (32'd1 << $urandom_range(31, 0));
      end
      PKT_OLD: begin
        id  = $urandom_range(sb.next_seq - 1, 0);
        crc = $urandom();
      end
      PKT_NEW: begin
        span = 64'hFFFF_FFFF - sb.next_seq;
        id   = ID_W'(sb.next_seq + 1 + ($urandom() % span));
        crc  = $urandom();
      end
      PKT_NEW_TOP: begin
        id = '1;
      end
      default: begin
      end
    endcase
    send_byte(b, 1'b1, id, crc, cnt);
  endtask

  // Lowers valid and waits until every owed ack has been transferred.
  task automatic wait_acks_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.awaited_acks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write on the configuration port: a setup phase, then an access phase.
  task automatic write_seed(input logic [CRC_W-1:0] v);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = SEED_ADDR;
    cfg_pwdata  = v;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.load_seed(v);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  function automatic pkt_kind_t pick_kind();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return PKT_GOOD;
    if (r < 75) return PKT_BAD_CRC;
    if (r < 88) return PKT_OLD;
    return PKT_NEW;
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    if ($urandom_range(7, 0) == 0) return COUNT_W'($urandom_range(2047, PAYLOAD_CAP + 1));
    return COUNT_W'($urandom_range(PAYLOAD_CAP, 0));
  endfunction

  // Main sequence.
  initial begin
    logic [CRC_W-1:0] phase_seed;
    int               len;
    int               goal;
    bit               paused;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening under the reset seed: all verdicts and count limits.
    send_packet(1, PKT_GOOD, '0, 8'h00);
    send_packet(1, PKT_GOOD, COUNT_W'(PAYLOAD_CAP), 8'hFF);
    send_packet(2, PKT_BAD_CRC, COUNT_W'(PAYLOAD_CAP + 1), -1);
    send_packet(3, PKT_GOOD, '1, -1);
    send_packet(1, PKT_OLD, 11'd5, -1);
    send_packet(2, PKT_NEW_TOP, 11'd7, -1);
    send_packet(1, PKT_NEW, 11'd9, -1);

    // A seed write in the middle of a packet restarts its CRC.
    send_byte(8'hA5, 1'b0, '1, '1, '1);
    send_byte(8'h5A, 1'b0, '0, '0, '0);
    wait_acks_drained();
    write_seed('0);
    send_packet(2, PKT_GOOD, 11'd3, -1);
    wait_acks_drained();
    write_seed(32'h1234_5678);
    send_packet(1, PKT_BAD_CRC, 11'd1, -1);
    send_packet(1, PKT_GOOD, 11'd1, -1);

    // Random phases, each under its own seed; the third runs with no idling.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       phase_seed = '0;
        2:       phase_seed = '1;
        default: phase_seed = $urandom();
      endcase
      wait_acks_drained();
      write_seed(phase_seed);
      hush   = (phase == 2);
      goal   = bytes_sent + PHASE_BYTES;
      paused = 1'b0;
      while (bytes_sent < goal) begin
        len = ($urandom_range(19, 0) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        send_packet(len, pick_kind(), pick_count(), -1);
        // In the second phase, let the result side catch up completely once mid-phase.
        if (phase == 1 && !paused && bytes_sent > goal - PHASE_BYTES / 2) begin
          paused = 1'b1;
          wait_acks_drained();
        end
      end
    end
    hush = 1'b0;

    wait_acks_drained();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited_acks.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
